### rtl/core/qtd_pkg.sv
`default_nettype none
package qtd_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_DEPTH_DEF  = 12;
    localparam int COORD_BITS_DEF = 13;

    // Configuration register
    localparam int             CFG_W      = 13;
    localparam logic [CFG_W-1:0] SIDE_RESET = 13'd256;

    // Stream markers
    localparam logic [7:0] MARK_SPLIT = 8'h4E;  // 'N'
    localparam logic [7:0] MARK_LEAF  = 8'h48;  // 'H'

    // Command queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_SPLIT,
        CMD_LEAF,
        CMD_CLOSE
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [31:0] rgba;
    } t_cmd;

    typedef enum logic [2:0] {
        PH_MARKER,
        PH_RED,
        PH_GREEN,
        PH_BLUE,
        PH_ALPHA
    } t_phase;

endpackage
`default_nettype wire

### rtl/core/qtd_front.sv
`default_nettype none
module qtd_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic [7:0]   i_byte,
    input  wire logic         i_full,
    output logic              o_stall,
    output logic              o_push,
    output qtd_pkg::t_cmd     o_cmd
);

    qtd_pkg::t_phase r_phase, n_phase;
    logic [23:0]     r_hold, n_hold;
    logic            accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;

    // next state
    always_comb begin
        n_phase = r_phase;
        n_hold  = r_hold;
        if (accept) begin
            case (r_phase)
                qtd_pkg::PH_MARKER: begin
                    if (i_byte == qtd_pkg::MARK_LEAF) begin
                        n_phase = qtd_pkg::PH_RED;
                        n_hold  = '0;
                    end
                end
                qtd_pkg::PH_RED: begin
                    n_phase = qtd_pkg::PH_GREEN;
                    n_hold  = {r_hold[15:0], i_byte};
                end
                qtd_pkg::PH_GREEN: begin
                    n_phase = qtd_pkg::PH_BLUE;
                    n_hold  = {r_hold[15:0], i_byte};
                end
                qtd_pkg::PH_BLUE: begin
                    n_phase = qtd_pkg::PH_ALPHA;
                    n_hold  = {r_hold[15:0], i_byte};
                end
                qtd_pkg::PH_ALPHA: begin
                    n_phase = qtd_pkg::PH_MARKER;
                    n_hold  = '0;
                end
                default: begin
                    n_phase = qtd_pkg::PH_MARKER;
                end
            endcase
        end
    end

    // outputs: at most one command per byte
    always_comb begin
        o_push      = 1'b0;
        o_cmd.kind  = qtd_pkg::CMD_CLOSE;
        o_cmd.rgba  = '0;
        case (r_phase)
            qtd_pkg::PH_MARKER: begin
                if (i_byte == qtd_pkg::MARK_SPLIT) begin
                    o_push     = accept;
                    o_cmd.kind = qtd_pkg::CMD_SPLIT;
                end else if (i_byte != qtd_pkg::MARK_LEAF) begin
                    o_push     = accept;
                    o_cmd.kind = qtd_pkg::CMD_CLOSE;
                end
            end
            qtd_pkg::PH_ALPHA: begin
                o_push     = accept;
                o_cmd.kind = qtd_pkg::CMD_LEAF;
                o_cmd.rgba = {r_hold, i_byte};
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= qtd_pkg::PH_MARKER;
            r_hold  <= '0;
        end else begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
        end
    end

endmodule
`default_nettype wire

### rtl/core/qtd_fifo.sv
`default_nettype none
module qtd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  qtd_pkg::t_cmd      i_cmd,
    output logic               o_full,
    output logic               o_valid,
    output qtd_pkg::t_cmd      o_cmd,
    input  wire logic          i_pop
);

    qtd_pkg::t_cmd                 r_mem [qtd_pkg::Q_DEPTH];
    logic [qtd_pkg::Q_PTR_W-1:0]   r_wptr, r_rptr;
    logic [qtd_pkg::Q_CNT_W-1:0]   r_count;
    logic                          do_push, do_pop;

    assign o_full  = (r_count == qtd_pkg::Q_CNT_W'(qtd_pkg::Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + qtd_pkg::Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + qtd_pkg::Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + qtd_pkg::Q_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - qtd_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

### rtl/core/qtd_back.sv
`default_nettype none
module qtd_back #(
    parameter int MAX_DEPTH  = qtd_pkg::MAX_DEPTH_DEF,
    parameter int COORD_BITS = qtd_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cmd_valid,
    input  qtd_pkg::t_cmd              i_cmd,
    output logic                       o_cmd_pop,
    input  wire logic [COORD_BITS-1:0] i_side,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [COORD_BITS-1:0]      o_x_start,
    output logic [COORD_BITS-1:0]      o_x_end,
    output logic [COORD_BITS-1:0]      o_y_start,
    output logic [COORD_BITS-1:0]      o_y_end,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [7:0]                 o_alpha,
    output logic                       o_paint,
    output logic                       o_tree_done,
    output logic                       o_depth_error
);

    localparam int LVL_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    typedef struct packed {
        logic [COORD_BITS-1:0] xs;
        logic [COORD_BITS-1:0] xe;
        logic [COORD_BITS-1:0] ys;
        logic [COORD_BITS-1:0] ye;
    } t_rect;

    function automatic t_rect sub_rect(t_rect p, logic [1:0] c);
        logic [COORD_BITS-1:0] diff;
        logic [COORD_BITS-1:0] h;
        logic [COORD_BITS-1:0] xm;
        logic [COORD_BITS-1:0] ym;
        t_rect                 r;
        diff = p.xe - p.xs;
        h    = {1'b0, diff[COORD_BITS-1:1]};
        xm   = p.xs + h;
        ym   = p.ys + h;
        r.xs = c[0] ? xm   : p.xs;
        r.xe = c[0] ? p.xe : xm;
        r.ys = c[1] ? ym   : p.ys;
        r.ye = c[1] ? p.ye : ym;
        return r;
    endfunction

    t_rect             r_stack [MAX_DEPTH];
    logic [1:0]        r_child [MAX_DEPTH];
    logic [LVL_W-1:0]  r_level;
    t_rect             r_cur;
    logic              r_out_valid;

    t_rect             root, cur, push_cur, close_cur;
    logic              out_ready, exec, can_push, is_split, is_push, is_close;
    logic [MAX_DEPTH-1:0] open_lvl;
    logic              found;
    logic [IDX_W-1:0]  sel;
    logic [1:0]        child_nx;

    always_comb begin
        root.xs = '0;
        root.xe = i_side;
        root.ys = '0;
        root.ye = i_side;
        // at the root the region follows the side register directly
        cur       = (r_level == '0) ? root : r_cur;
        out_ready = !r_out_valid || !i_out_stall;
        exec      = i_cmd_valid && out_ready;
        can_push  = (r_level < LVL_W'(MAX_DEPTH));
        is_split  = (i_cmd.kind == qtd_pkg::CMD_SPLIT);
        is_push   = exec && is_split && can_push;
        is_close  = exec && !(is_split && can_push);
        push_cur  = sub_rect(cur, 2'd0);
    end

    // deepest ancestor that still has a sibling to visit
    always_comb begin
        found = 1'b0;
        sel   = '0;
        for (int i = 0; i < MAX_DEPTH; i++) begin
            open_lvl[i] = (LVL_W'(i) < r_level) && (r_child[i] != 2'd3);
        end
        for (int i = 0; i < MAX_DEPTH; i++) begin
            if (open_lvl[i]) begin
                found = 1'b1;
                sel   = IDX_W'(i);
            end
        end
        child_nx  = r_child[sel] + 2'd1;
        close_cur = sub_rect(r_stack[sel], child_nx);
    end

    assign o_cmd_pop   = exec;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (is_push) begin
                r_level <= r_level + LVL_W'(1);
            end else if (is_close) begin
                r_level <= found ? (LVL_W'(sel) + LVL_W'(1)) : '0;
            end
            if (is_close) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_push) begin
            r_stack[r_level[IDX_W-1:0]] <= cur;
            r_child[r_level[IDX_W-1:0]] <= 2'd0;
            r_cur                       <= push_cur;
        end
        if (is_close) begin
            if (found) begin
                r_child[sel] <= child_nx;
                r_cur        <= close_cur;
            end
            o_x_start     <= cur.xs;
            o_x_end       <= cur.xe;
            o_y_start     <= cur.ys;
            o_y_end       <= cur.ye;
            o_paint       <= (i_cmd.kind == qtd_pkg::CMD_LEAF);
            o_depth_error <= is_split;
            o_tree_done   <= !found;
            if (i_cmd.kind == qtd_pkg::CMD_LEAF) begin
                o_red   <= i_cmd.rgba[31:24];
                o_green <= i_cmd.rgba[23:16];
                o_blue  <= i_cmd.rgba[15:8];
                o_alpha <= i_cmd.rgba[7:0];
            end else begin
                o_red   <= '0;
                o_green <= '0;
                o_blue  <= '0;
                o_alpha <= '0;
            end
        end
    end

endmodule
`default_nettype wire

### rtl/core/quadtree_image_stream_decoder_top.sv
// Path: a byte that completes a command goes through the command queue, then the output register.
// Throughput: one byte per cycle while the queue has room; a close (sibling search over the
//   ancestor levels, next child region) is combinational, so the queue drains at line rate unless the output stalls.
// Reset: synchronous, active low. Walk returns to the root, marker phase, queue empty,
//   image_side = 256. Region and child stacks are not cleared; they are written before use.
`default_nettype none
module quadtree_image_stream_decoder_top #(
    parameter int MAX_DEPTH  = qtd_pkg::MAX_DEPTH_DEF,
    parameter int COORD_BITS = qtd_pkg::COORD_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // stream input transaction
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [7:0]                   i_stream_byte,
    // result transaction
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [COORD_BITS-1:0]             o_x_start,
    output logic [COORD_BITS-1:0]             o_x_end,
    output logic [COORD_BITS-1:0]             o_y_start,
    output logic [COORD_BITS-1:0]             o_y_end,
    output logic [7:0]                        o_red,
    output logic [7:0]                        o_green,
    output logic [7:0]                        o_blue,
    output logic [7:0]                        o_alpha,
    output logic                              o_paint,
    output logic                              o_tree_done,
    output logic                              o_depth_error,
    // configuration write transaction
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [qtd_pkg::CFG_W-1:0]    i_cfg_image_side
);

    // Side register; taken in whenever a walk is at the root.
    logic [qtd_pkg::CFG_W-1:0] r_image_side;
    logic [COORD_BITS-1:0]     side_c;

    // Front -> queue -> back command path
    logic          fr_push;
    qtd_pkg::t_cmd fr_cmd;
    logic          q_full;
    logic          q_valid;
    qtd_pkg::t_cmd q_cmd;
    logic          bk_pop;

    assign o_cfg_ready = 1'b1;
    // side is masked (or zero-extended) to the coordinate width
    assign side_c      = COORD_BITS'(r_image_side);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_side <= qtd_pkg::SIDE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_image_side <= i_cfg_image_side;
        end
    end

    // Front: tracks marker / colour phase and packs colour bytes into one command.
    qtd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_stream_byte),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (fr_push),
        .o_cmd   (fr_cmd)
    );

    // Short command queue so either side can stall independently.
    qtd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .i_cmd   (fr_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (bk_pop)
    );

    // Back: region stack walk and the result register.
    qtd_back #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (q_valid),
        .i_cmd         (q_cmd),
        .o_cmd_pop     (bk_pop),
        .i_side        (side_c),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_x_start     (o_x_start),
        .o_x_end       (o_x_end),
        .o_y_start     (o_y_start),
        .o_y_end       (o_y_end),
        .o_red         (o_red),
        .o_green       (o_green),
        .o_blue        (o_blue),
        .o_alpha       (o_alpha),
        .o_paint       (o_paint),
        .o_tree_done   (o_tree_done),
        .o_depth_error (o_depth_error)
    );

endmodule
`default_nettype wire

### rtl/core/qtd_checker.sv
`default_nettype none
module qtd_checker #(
    parameter int COORD_BITS = qtd_pkg::COORD_BITS_DEF
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic [COORD_BITS-1:0] o_x_start,
    input wire logic [COORD_BITS-1:0] o_x_end,
    input wire logic [7:0]            o_red,
    input wire logic [7:0]            o_green,
    input wire logic [7:0]            o_blue,
    input wire logic [7:0]            o_alpha,
    input wire logic                  o_paint,
    input wire logic                  o_tree_done,
    input wire logic                  o_depth_error
);

    // held result must not move
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_x_start) && $stable(o_x_end)
            && $stable(o_paint) && $stable(o_tree_done) && $stable(o_depth_error))
        else $error("stalled result changed");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_paint_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_paint |-> !o_depth_error)
        else $error("painted leaf flagged as depth error");

    a_unpaint_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_paint |-> (o_red == 8'd0) && (o_green == 8'd0)
            && (o_blue == 8'd0) && (o_alpha == 8'd0))
        else $error("unpainted node carries colour");

endmodule

bind quadtree_image_stream_decoder_top qtd_checker #(.COORD_BITS(COORD_BITS)) u_qtd_checker (.*);
`default_nettype wire
